// File: rtl/core/lz78_pkg.sv
// ----------------------------------------------------------------------------
// lz78_pkg
// Shared constants, controller states and the command and status groups
// that pass between the lz78 controller and datapath.
// ----------------------------------------------------------------------------
package lz78_pkg;

   localparam int CODE_BITS_DEF  = 12;
   localparam int HASH_SLOTS_DEF = 8192;
   localparam int BYTE_W         = 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CMP,
      ST_PACK,
      ST_DRAIN,
      ST_FLUSH
   } lz_state_type;

   typedef struct packed {
      logic accept;
      logic hash_step;
      logic compare;
      logic pack;
      logic emit;
      logic flush;
      logic clear_step;
   } lz_cmd_type;

   typedef struct packed {
      logic hash_done;
      logic slot_empty;
      logic slot_match;
      logic probe_over;
      logic bits_ge8;
      logic out_free;
      logic item_last;
      logic clear_done;
   } lz_status_type;

endpackage

// File: rtl/core/lz78_ifs.sv
// ----------------------------------------------------------------------------
// lz78 channel interfaces
// Request channel (source bytes) and response channel (packed bytes).
// ----------------------------------------------------------------------------
interface lz78_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lz78_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       dict_full;
   modport source (output valid, output out_byte, output out_last, output dict_full,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input dict_full,
                   output ready);
endinterface

// File: rtl/core/lz78_ram.sv
// ----------------------------------------------------------------------------
// lz78_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lz78_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/lz78_ctrl.sv
// ----------------------------------------------------------------------------
// lz78_ctrl
// Sequencer: clearing pass, hash, probe loop, packing, drain and flush.
// ----------------------------------------------------------------------------
module lz78_ctrl
   import lz78_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  lz_status_type status,
   output lz_cmd_type    cmd
);

   lz_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (status.hash_done) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            if (status.slot_empty || status.slot_match || status.probe_over) begin
               state_in = ST_PACK;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_PACK: begin
            cmd.pack = 1'b1;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            priority if (status.bits_ge8) begin
               cmd.emit = status.out_free;
            end else if (status.item_last) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_CLEAR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

// File: rtl/core/lz78_dpath.sv
// ----------------------------------------------------------------------------
// lz78_dpath
// Hash unit, probe address, dictionary RAM, code allocation, bit packer
// and the response register.
// ----------------------------------------------------------------------------
module lz78_dpath
   import lz78_pkg::*;
#(
   parameter int CODE_BITS  = CODE_BITS_DEF,
   parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  lz_cmd_type    cmd,
   output lz_status_type status,
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [7:0]    out_byte,
   output logic          out_last,
   output logic          dict_full
);

   localparam int AW     = $clog2(HASH_SLOTS);
   localparam int PW     = $clog2(HASH_SLOTS + 1);
   localparam int KEY_W  = CODE_BITS + BYTE_W;
   localparam int HCW    = 2;
   localparam int CWW    = $clog2(CODE_BITS + 1);
   localparam int ACC_W  = CODE_BITS + BYTE_W + 7;
   localparam int CNTW   = $clog2(ACC_W + 1);
   localparam int MEM_W  = 2 * CODE_BITS + BYTE_W + 1;
   localparam int PROD_W = 2 * KEY_W;
   localparam int SH     = KEY_W + AW - 1;
   localparam int RW     = ((KEY_W > AW) ? KEY_W : AW) + 1;
   localparam bit POW2   = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
   localparam logic [AW-1:0] LAST_SLOT = AW'(HASH_SLOTS - 1);
   localparam logic [AW:0]   SLOTS_X   = (AW + 1)'(HASH_SLOTS);
   localparam logic [PW-1:0] SLOTS_P   = PW'(HASH_SLOTS);
   localparam logic [RW-1:0] MODV      = RW'(HASH_SLOTS);
   localparam logic [63:0]   RECIP_L   = (64'd1 << SH) / 64'(HASH_SLOTS);
   localparam logic [KEY_W-1:0] RECIP  = KEY_W'(RECIP_L);

   // item and hash
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [AW:0]        rem_ff, rem_in;
   logic [HCW-1:0]     hcnt_ff, hcnt_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [PW-1:0]      pcnt_ff, pcnt_in;
   logic               hit_ff, hit_in;
   logic               slot_ok_ff, slot_ok_in;
   logic [CODE_BITS-1:0] child_ff, child_in;
   // coder state
   logic [CODE_BITS-1:0] cur_ff, cur_in;
   logic [CODE_BITS-1:0] lcode_ff, lcode_in;
   logic [CWW-1:0]       cw_ff, cw_in;
   logic [CODE_BITS:0]   border_ff, border_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [AW-1:0]        clr_ff, clr_in;
   // response register
   logic       ov_ff, ov_in;
   logic [7:0] ob_ff, ob_in;
   logic       ol_ff, ol_in;
   logic       of_ff, of_in;

   logic              we;
   logic [AW-1:0]     waddr;
   logic [MEM_W-1:0]  wdata, rdata;

   logic                 ent_valid, ent_match;
   logic [KEY_W-1:0]     quot;
   logic [AW-1:0]        rem_fix;
   logic [KEY_W+AW-1:0]  key_x;
   logic [CODE_BITS:0]   one_sh, mask;
   logic [CODE_BITS-1:0] code_m;
   logic [ACC_W-1:0]     val;
   logic                 grow, add_ok;

   lz78_ram #(.WIDTH(MEM_W), .DEPTH(HASH_SLOTS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   assign ent_valid = rdata[MEM_W-1];
   assign ent_match = ent_valid && (rdata[MEM_W-2 -: CODE_BITS] == cur_ff)
                      && (rdata[CODE_BITS+7 -: 8] == byte_ff);

   // quotient estimate is exact or one low, so one subtract corrects it
   assign quot    = KEY_W'(prod_ff >> SH);
   assign rem_fix = (rem_ff >= SLOTS_X) ? AW'(rem_ff - SLOTS_X) : rem_ff[AW-1:0];
   assign key_x   = (KEY_W + AW)'(key_ff);
   assign one_sh  = (CODE_BITS + 1)'(1) << cw_ff;
   assign mask    = one_sh - (CODE_BITS + 1)'(1);
   assign code_m  = cur_ff & mask[CODE_BITS-1:0];
   assign val     = ACC_W'(code_m) | (ACC_W'(byte_ff) << cw_ff);
   assign grow    = {1'b0, lcode_ff} >= (border_ff - (CODE_BITS + 1)'(1));
   assign add_ok  = slot_ok_ff && !(grow && (cw_ff >= CWW'(CODE_BITS)));

   always_comb begin
      byte_in = byte_ff;   last_in = last_ff;   key_in = key_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;     hcnt_in = hcnt_ff;   idx_in = idx_ff;
      pcnt_in = pcnt_ff;   hit_in = hit_ff;     slot_ok_in = slot_ok_ff;
      child_in = child_ff; cur_in = cur_ff;     lcode_in = lcode_ff;
      cw_in = cw_ff;       border_in = border_ff;
      acc_in = acc_ff;     cnt_in = cnt_ff;     ovf_in = ovf_ff;
      clr_in = clr_ff;
      ov_in = ov_ff && !rsp_ready;
      ob_in = ob_ff;       ol_in = ol_ff;       of_in = of_ff;
      we = 1'b0;  waddr = clr_ff;  wdata = '0;

      if (cmd.clear_step) begin
         we     = 1'b1;
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.accept) begin
         byte_in = in_byte;
         last_in = in_last;
         key_in  = {cur_ff, in_byte};
         hcnt_in = HCW'(3);
         pcnt_in = '0;
      end
      if (cmd.hash_step) begin
         // reciprocal multiply, then remainder, then the correcting subtract
         if (hcnt_ff == HCW'(3)) begin
            prod_in = PROD_W'(key_ff) * PROD_W'(RECIP);
         end else if (hcnt_ff == HCW'(2)) begin
            rem_in = (AW + 1)'(RW'(key_ff) - RW'(quot) * MODV);
         end
         hcnt_in = hcnt_ff - HCW'(1);
         idx_in  = POW2 ? key_x[AW-1:0] : rem_fix;
      end
      if (cmd.compare) begin
         hit_in     = ent_match;
         slot_ok_in = !ent_valid;
         child_in   = rdata[CODE_BITS-1:0];
         if (ent_valid && !ent_match) begin
            idx_in  = (idx_ff == LAST_SLOT) ? '0 : idx_ff + AW'(1);
            pcnt_in = pcnt_ff + PW'(1);
         end
      end
      if (cmd.pack) begin
         if (!hit_ff || last_ff) begin
            acc_in = acc_ff | (val << cnt_ff);
            cnt_in = cnt_ff + CNTW'(cw_ff) + CNTW'(BYTE_W);
         end
         if (hit_ff) begin
            cur_in = child_ff;
         end else begin
            cur_in = '0;
            if (add_ok) begin
               if (grow) begin
                  border_in = border_ff << 1;
                  cw_in     = cw_ff + CWW'(1);
               end
               lcode_in = lcode_ff + CODE_BITS'(1);
               we       = 1'b1;
               waddr    = idx_ff;
               wdata    = {1'b1, cur_ff, byte_ff, lcode_in};
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
      if (cmd.emit) begin
         ov_in  = 1'b1;
         ob_in  = acc_ff[7:0];
         ol_in  = 1'b0;
         of_in  = ovf_ff;
         acc_in = acc_ff >> 8;
         cnt_in = cnt_ff - CNTW'(BYTE_W);
      end
      if (cmd.flush) begin
         ov_in     = 1'b1;
         ob_in     = acc_ff[7:0];
         ol_in     = 1'b1;
         of_in     = ovf_ff;
         cur_in    = '0;
         lcode_in  = '0;
         cw_in     = CWW'(1);
         border_in = (CODE_BITS + 1)'(2);
         acc_in    = '0;
         cnt_in    = '0;
         clr_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         lcode_ff  <= '0;
         cw_ff     <= CWW'(1);
         border_ff <= (CODE_BITS + 1)'(2);
         acc_ff    <= '0;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         clr_ff    <= '0;
         ov_ff     <= 1'b0;
      end else begin
         cur_ff    <= cur_in;
         lcode_ff  <= lcode_in;
         cw_ff     <= cw_in;
         border_ff <= border_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         clr_ff    <= clr_in;
         ov_ff     <= ov_in;
      end
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      key_ff     <= key_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      hcnt_ff    <= hcnt_in;
      idx_ff     <= idx_in;
      pcnt_ff    <= pcnt_in;
      hit_ff     <= hit_in;
      slot_ok_ff <= slot_ok_in;
      child_ff   <= child_in;
      ob_ff      <= ob_in;
      ol_ff      <= ol_in;
      of_ff      <= of_in;
   end

   always_comb begin
      status.hash_done  = POW2 || (hcnt_ff == HCW'(1));
      status.slot_empty = !ent_valid;
      status.slot_match = ent_match;
      status.probe_over = (pcnt_ff + PW'(1)) == SLOTS_P;
      status.bits_ge8   = cnt_ff >= CNTW'(BYTE_W);
      status.out_free   = !ov_ff || rsp_ready;
      status.item_last  = last_ff;
      status.clear_done = clr_ff == LAST_SLOT;
   end

   assign rsp_valid = ov_ff;
   assign out_byte  = ob_ff;
   assign out_last  = ol_ff;
   assign dict_full = of_ff;

endmodule

// File: rtl/core/lz78_encoder.sv
// ----------------------------------------------------------------------------
// lz78_encoder
// LZ78 compressor with growing code width, hashed dictionary in RAM and
// LSB-first bit packing into bytes.
// ----------------------------------------------------------------------------
//  channel  direction  payload                          handshake
//  req      in         in_byte[7:0], in_last             valid/ready
//  rsp      out        out_byte[7:0], out_last, dict_full valid/ready
//
//  a byte passes the hash, a RAM read and compare per probe on collisions,
//  packing and a drain of its output bytes; the probe loop on the single
//  RAM read port sets the pace; a slot count that is not a power of two
//  adds a multiply, remainder and correcting subtract to the hash; after
//  reset and every final byte a clearing pass of all HASH_SLOTS slots runs
//  with req.ready low; the final byte adds a flush; a stalled response
//  holds the drain and the flush; the response register keeps data
// ----------------------------------------------------------------------------
module lz78_encoder
   import lz78_pkg::*;
#(
   parameter int CODE_BITS  = CODE_BITS_DEF,
   parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lz78_req_if.sink    req,
   lz78_rsp_if.source  rsp
);

   lz_cmd_type    cmd;
   lz_status_type status;
   logic          ready;

   lz78_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   lz78_dpath #(.CODE_BITS(CODE_BITS), .HASH_SLOTS(HASH_SLOTS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_byte   (req.in_byte),
      .in_last   (req.in_last),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .out_byte  (rsp.out_byte),
      .out_last  (rsp.out_last),
      .dict_full (rsp.dict_full)
   );

   assign req.ready = ready;

endmodule

// File: rtl/core/lz78_chk.sv
// ----------------------------------------------------------------------------
// lz78_chk
// Port-level checks on the encoder, attached by bind.
// ----------------------------------------------------------------------------
module lz78_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       out_last,
   input logic       dict_full
);

   logic seen_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_full_ff <= 1'b0;
      end else if (rsp_valid && dict_full) begin
         seen_full_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte)
         && $stable(out_last) && $stable(dict_full))
      else $error("response changed while stalled");

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_full_ff |-> dict_full)
      else $error("dictionary full flag dropped");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request ready before clearing pass");

endmodule

bind lz78_encoder lz78_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .out_byte  (rsp.out_byte),
   .out_last  (rsp.out_last),
   .dict_full (rsp.dict_full)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_encoder testbench
// Feeds source blocks through the request channel and checks every packed
// byte against a behavioural encoder that keeps its own hashed dictionary,
// code width and bit packer.
// Runs under several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import lz78_pkg::*;

   localparam int CODE_W = CODE_BITS_DEF;
   localparam int SLOTS  = HASH_SLOTS_DEF;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       full;
   } packed_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lz78_req_if req ();
   lz78_rsp_if rsp ();

   lz78_encoder DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #4 clock = ~clock;

   // encoder state kept by the bench
   bit          dict_valid  [SLOTS];
   int unsigned dict_parent [SLOTS];
   logic [7:0]  dict_sym    [SLOTS];
   int unsigned dict_child  [SLOTS];
   int unsigned phrase_code, prefix_code, top_code, width, border, pend_bits;
   longint unsigned pend_acc;
   bit          overflowed;

   packed_byte_type expected_bytes[$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          errors = 0;
   int          bytes_checked = 0;
   int          items_sent = 0;
   int          blocks_sent = 0;

   function automatic void clear_dictionary();
      foreach (dict_valid[i]) dict_valid[i] = 1'b0;
      phrase_code = 0;
      prefix_code = 0;
      top_code    = 0;
      width       = 1;
      border      = 2;
      pend_acc    = 0;
      pend_bits   = 0;
   endfunction

   function automatic void pack_bits(input int unsigned v, input int unsigned w);
      longint unsigned mask;
      mask = (64'd1 << w) - 1;
      pend_acc  = pend_acc | ((longint'(v) & mask) << pend_bits);
      pend_bits = pend_bits + w;
   endfunction

   function automatic void encode_byte(input logic [7:0] b, input logic last);
      int          idx;
      int          slot;
      bit          hit;
      bit          grow;
      packed_byte_type o;
      idx  = ((phrase_code << 8) | b) % SLOTS;
      slot = -1;
      hit  = 1'b0;
      for (int n = 0; n < SLOTS; n++) begin
         if (!dict_valid[idx]) begin
            slot = idx;
            break;
         end
         if (dict_parent[idx] == phrase_code && dict_sym[idx] == b) begin
            slot = idx;
            hit  = 1'b1;
            break;
         end
         idx = (idx + 1) % SLOTS;
      end
      if (hit) begin
         prefix_code = phrase_code;
         phrase_code = dict_child[slot];
         if (last) begin
            pack_bits(prefix_code, width);
            pack_bits(b, 8);
         end
      end else begin
         pack_bits(phrase_code, width);
         pack_bits(b, 8);
         grow = top_code >= border - 1;
         if (slot < 0 || (grow && width >= CODE_W)) begin
            overflowed = 1'b1;
         end else begin
            if (grow) begin
               border = border << 1;
               width  = width + 1;
            end
            top_code          = top_code + 1;
            dict_valid[slot]  = 1'b1;
            dict_parent[slot] = phrase_code;
            dict_sym[slot]    = b;
            dict_child[slot]  = top_code;
         end
         phrase_code = 0;
         prefix_code = 0;
      end
      while (pend_bits >= 8) begin
         o.data = pend_acc[7:0];
         o.last = 1'b0;
         o.full = overflowed;
         expected_bytes.push_back(o);
         pend_acc  = pend_acc >> 8;
         pend_bits = pend_bits - 8;
      end
      if (last) begin
         o.data = pend_acc[7:0];
         o.last = 1'b1;
         o.full = overflowed;
         expected_bytes.push_back(o);
         clear_dictionary();
      end
   endfunction

   // one request; valid stays high across back-to-back requests
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req.valid = 1'b0;
      end
      @(negedge clock);
      req.valid   = 1'b1;
      req.in_byte = b;
      req.in_last = last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      encode_byte(b, last);
      items_sent++;
      if (last) blocks_sent++;
   endtask

   task automatic go_idle();
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic wait_drained();
      go_idle();
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_symbol(input int wide_pct, input int alpha);
      if ($urandom_range(99) < wide_pct) return 8'($urandom);
      return 8'('h61 + $urandom_range(alpha - 1));
   endfunction

   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else       rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected output byte %02h last=%b full=%b", rsp.out_byte,
                        rsp.out_last, rsp.dict_full);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp.out_byte !== want.data || rsp.out_last !== want.last ||
                rsp.dict_full !== want.full) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %02h last=%b full=%b, got %02h last=%b full=%b",
                           want.data, want.last, want.full, rsp.out_byte, rsp.out_last,
                           rsp.dict_full);
            end
         end
      end
   end

   // extremes, repeats that build phrases, last on a matched byte and on a miss
   task automatic test_directed();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h01, 1'b1);
      for (int i = 0; i < 7; i++) send_byte(8'h80 >> i, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   // well-formed blocks; a narrow alphabet grows long phrases and wide codes
   task automatic test_random_blocks(input int count);
      int n;
      int len;
      int alpha;
      int wide;
      n = 0;
      while (n < count) begin
         len   = ($urandom_range(9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 40);
         alpha = $urandom_range(1, 16);
         wide  = $urandom_range(9) < 2 ? 100 : 10;
         for (int i = 0; i < len; i++) send_byte(pick_symbol(wide, alpha), i == len - 1);
         n += len;
      end
   endtask

   // sender holds off in the middle of a block until every expected response has come back
   task automatic test_pause();
      for (int i = 0; i < 6; i++) send_byte(pick_symbol(0, 2), 1'b0);
      wait_drained();
      for (int i = 0; i < 6; i++) send_byte(pick_symbol(0, 2), i == 5);
   endtask

   initial begin
      req.valid   = 1'b0;
      req.in_byte = 8'h00;
      req.in_last = 1'b0;
      overflowed  = 1'b0;
      clear_dictionary();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_blocks(80);
      send_idle_pct = 48;
      test_random_blocks(70);
      test_pause();
      send_idle_pct  = 0;
      recv_stall_pct = 48;
      test_random_blocks(70);
      send_idle_pct = 9;
      recv_stall_pct = 9;
      test_random_blocks(70);

      wait_drained();
      repeat (60) @(posedge clock);
      errors += expected_bytes.size();
      $display("%0d source bytes in %0d blocks, %0d packed bytes checked", items_sent,
               blocks_sent, bytes_checked);
      $display("idle and stall patterns on both channels, with a drained pause");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d errors", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
